// File: sv/ppc_pkg.sv
// Package for the piston position controller.
// Types, codes and widths shared by ppc_step, the top level and its checker.
`default_nettype none

package ppc_pkg;

  localparam int POS_W = 16;
  localparam int DEB_W = 7;
  localparam int STALL_W = 16;
  localparam int SPD_W = 8;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_BUSY  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FN_TICK       = 2'd0,
    FN_GOTO_READY = 2'd1,
    FN_GOTO_SPEED = 2'd2,
    FN_RESTART    = 2'd3
  } func_t;

  localparam logic [CFG_AW-1:0] REG_AUTO_CONTROL = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CALIBRATION  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_STALL_TICKS  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SENSOR_HOLD  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SLOW_ZONE    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_FULL_SPEED   = 3'd5;

  typedef struct packed {
    logic               auto_control;
    logic               calibration_mode;
    logic [STALL_W-1:0] stall_ticks;
    logic [DEB_W-1:0]   sensor_hold;
    logic [7:0]         slow_zone;
    logic [SPD_W-1:0]   full_speed;
  } cfg_t;

  typedef struct packed {
    pos_t               cur_pos;
    pos_t               last_pos;
    pos_t               dest_pos;
    logic [STALL_W-1:0] stall_cnt;
    logic [DEB_W-1:0]   deb_cnt;
    logic               prev_optic;
    logic               spent;
    status_t            status;
    logic               run;
    logic               dir;
    logic [SPD_W-1:0]   speed;
    logic               done;
  } st_t;

endpackage

`default_nettype wire

// File: sv/piston_position_controller.sv
// Piston position controller: top level with state, configuration and result registers.
// Depends on ppc_pkg and ppc_step.
//
// Use:
//   Input channel (in_valid/in_ready) carries one request: in_func selects tick,
//   go-to forcing ready, go-to with speed or restart; in_optic_level is used by
//   a tick, in_target by go-to requests and in_speed by go-to with speed.
//   Result channel (out_valid/out_ready) returns one result per request: the
//   position, status, motor run/direction/speed and destination-complete flag
//   as they stand after that request.
//   Latency: the result is shown the cycle after the request is accepted.
//   Throughput: one request per cycle while results are taken; the whole step is
//   one pass of logic from the state registers to the next state and result register.
//   A request is taken while a result waits, as long as that result is being
//   taken in the same cycle; while the receiver stalls, in_ready is low and
//   the held result is unchanged.
//   Reset (rst_n low, synchronous) clears position, counters and motor state,
//   sets status ready, empties the result register and loads the register
//   defaults. Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect
//   at once; unknown indexes are ignored.
`default_nettype none

module piston_position_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic               in_optic_level,
  input  logic signed [15:0] in_target,
  input  logic [7:0]         in_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_position,
  output logic [1:0]         out_status,
  output logic               out_motor_run,
  output logic               out_motor_dir,
  output logic [7:0]         out_motor_speed,
  output logic               out_dest_complete,
  input  logic               cfg_we,
  input  logic [ppc_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [ppc_pkg::CFG_DW-1:0] cfg_wdata
);
  import ppc_pkg::*;

  st_t  st_r;
  st_t  st_nxt;
  cfg_t cfg_r;
  logic out_valid_r;
  logic accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  ppc_step u_step (
    .st          (st_r),
    .cfg         (cfg_r),
    .func        (in_func),
    .optic_level (in_optic_level),
    .target      (in_target),
    .speed       (in_speed),
    .st_nxt      (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_control     <= 1'b1;
      cfg_r.calibration_mode <= 1'b0;
      cfg_r.stall_ticks      <= STALL_W'(500);
      cfg_r.sensor_hold      <= DEB_W'(10);
      cfg_r.slow_zone        <= 8'd5;
      cfg_r.full_speed       <= SPD_W'(100);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_AUTO_CONTROL: cfg_r.auto_control     <= cfg_wdata[0];
        REG_CALIBRATION:  cfg_r.calibration_mode <= cfg_wdata[0];
        REG_STALL_TICKS:  cfg_r.stall_ticks      <= cfg_wdata[STALL_W-1:0];
        REG_SENSOR_HOLD:  cfg_r.sensor_hold      <= cfg_wdata[DEB_W-1:0];
        REG_SLOW_ZONE:    cfg_r.slow_zone        <= cfg_wdata[7:0];
        REG_FULL_SPEED:   cfg_r.full_speed       <= cfg_wdata[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{cur_pos: '0, last_pos: '0, dest_pos: '0, stall_cnt: '0,
                deb_cnt: '0, prev_optic: 1'b0, spent: 1'b0, status: ST_READY,
                run: 1'b0, dir: 1'b0, speed: '0, done: 1'b0};
      out_valid_r <= 1'b0;
    end else begin
      if (accept)
        st_r <= st_nxt;
      if (accept)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_position      <= 16'(st_nxt.cur_pos);
      out_status        <= st_nxt.status;
      out_motor_run     <= st_nxt.run;
      out_motor_dir     <= st_nxt.dir;
      out_motor_speed   <= st_nxt.speed;
      out_dest_complete <= st_nxt.done;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: sv/ppc_step.sv
// One request of the piston position controller: sensor debounce, control step, go-to and restart.
// Purely combinational; depends on ppc_pkg.
`default_nettype none

module ppc_step (
  input  ppc_pkg::st_t          st,
  input  ppc_pkg::cfg_t         cfg,
  input  logic [1:0]            func,
  input  logic                  optic_level,
  input  logic signed [15:0]    target,
  input  logic [7:0]            speed,
  output ppc_pkg::st_t          st_nxt
);
  import ppc_pkg::*;

  function automatic st_t control(st_t s_in, cfg_t c);
    st_t s;
    logic moved;
    logic signed [POS_W:0] diff;
    logic [POS_W:0] gap;
    s = s_in;
    if (s.status == ST_ERROR) begin
      s.run = 1'b0;
    end else begin
      moved = (s.cur_pos != s.last_pos);
      if (c.auto_control) begin
        if (s.cur_pos != s.dest_pos) begin
          if (s.status == ST_READY) begin
            s.dir = ($signed(s.cur_pos) > $signed(s.dest_pos));
            s.stall_cnt = c.stall_ticks;
            s.status = ST_BUSY;
            s.done = 1'b0;
            s.run = 1'b1;
          end
          if (!moved) begin
            s.stall_cnt = s.stall_cnt - 1'b1;
            if (s.stall_cnt == '0) begin
              s.stall_cnt = STALL_W'(1);
              s.run = 1'b0;
              s.status = c.calibration_mode ? ST_READY : ST_ERROR;
            end
          end else begin
            s.stall_cnt = c.stall_ticks;
          end
          diff = $signed({s.dest_pos[POS_W-1], s.dest_pos})
               - $signed({s.cur_pos[POS_W-1], s.cur_pos});
          gap = diff[POS_W] ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);
          if (gap < (POS_W+1)'(c.slow_zone))
            s.speed = c.full_speed >> 1;
        end else begin
          s.done = 1'b1;
          s.run = 1'b0;
          s.status = ST_READY;
        end
      end
      s.last_pos = s.cur_pos;
    end
    return s;
  endfunction

  function automatic st_t go_to(st_t s_in, cfg_t c, logic signed [15:0] tgt,
                                logic [SPD_W-1:0] spd);
    st_t s;
    pos_t dest;
    s = s_in;
    dest = pos_t'(tgt);
    if (dest != s.cur_pos)
      s.dest_pos = dest;
    s.speed = spd;
    return control(s, c);
  endfunction

  st_t s_opt;

  // sensor debounce, at most one position step per high phase
  always_comb begin
    s_opt = st;
    if (s_opt.deb_cnt != '0)
      s_opt.deb_cnt = s_opt.deb_cnt - 1'b1;
    if (s_opt.prev_optic != optic_level) begin
      s_opt.deb_cnt = cfg.sensor_hold;
      s_opt.prev_optic = optic_level;
      s_opt.spent = 1'b0;
    end else if (s_opt.deb_cnt == '0 && optic_level && !s_opt.spent) begin
      s_opt.spent = 1'b1;
      s_opt.cur_pos = s_opt.dir ? s_opt.cur_pos - 1'b1 : s_opt.cur_pos + 1'b1;
    end
  end

  st_t s_rdy;

  always_comb begin
    s_rdy = st;
    s_rdy.status = ST_READY;
  end

  always_comb begin
    st_nxt = st;
    case (func_t'(func))
      FN_TICK:       st_nxt = control(s_opt, cfg);
      FN_GOTO_READY: st_nxt = go_to(s_rdy, cfg, target, cfg.full_speed);
      FN_GOTO_SPEED: st_nxt = go_to(st, cfg, target, speed);
      FN_RESTART: begin
        if (st.status == ST_ERROR)
          st_nxt.status = ST_READY;
      end
      default:       st_nxt = st;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/ppc_checker.sv
// Port-level checks for piston_position_controller, attached by bind.
// Depends on ppc_pkg.
`default_nettype none

module ppc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_position,
  input logic [1:0]         out_status,
  input logic               out_motor_run,
  input logic               out_dest_complete
);
  import ppc_pkg::*;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position)
                                && $stable(out_status))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ERROR |-> !out_motor_run && !out_dest_complete)
    else $error("motor running in error status");

endmodule

bind piston_position_controller ppc_checker u_ppc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_position      (out_position),
  .out_status        (out_status),
  .out_motor_run     (out_motor_run),
  .out_dest_complete (out_dest_complete)
);

`default_nettype wire

// File: tb/piston_position_controller_test.sv
// Self-checking testbench for piston_position_controller: directed and random requests
// against a predictor of the controller, with idling on both handshakes. Needs ppc_pkg.
`timescale 1ns / 100ps

module piston_position_controller_test;
  import ppc_pkg::*;

  typedef struct {
    logic [15:0] position;
    status_t     status;
    logic        motor_run;
    logic        motor_dir;
    logic [7:0]  motor_speed;
    logic        dest_complete;
  } reading_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  class piston_scoreboard;
    logic        auto_ctl;
    logic        calib;
    logic [15:0] stall_ticks;
    logic [6:0]  sensor_hold;
    logic [7:0]  slow_zone;
    logic [7:0]  full_speed;

    logic [15:0] cur;
    logic [15:0] last;
    logic [15:0] dest;
    logic [15:0] stall_cnt;
    logic [7:0]  deb;
    logic        prev_optic;
    logic        spent;
    status_t     status;
    logic        run;
    logic        dir;
    logic        done;
    logic [7:0]  speed;

    reading_t readings_due[$];
    int errors;
    int n_requests;
    int n_checked;
    int n_error_seen;
    int n_arrived;

    function new();
      auto_ctl = 1'b1;
      calib = 1'b0;
      stall_ticks = 16'd500;
      sensor_hold = 7'd10;
      slow_zone = 8'd5;
      full_speed = 8'd100;
      cur = '0;
      last = '0;
      dest = '0;
      stall_cnt = '0;
      deb = '0;
      prev_optic = 1'b0;
      spent = 1'b0;
      status = ST_READY;
      run = 1'b0;
      dir = 1'b0;
      done = 1'b0;
      speed = '0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_AUTO_CONTROL: auto_ctl = val[0];
        REG_CALIBRATION:  calib = val[0];
        REG_STALL_TICKS:  stall_ticks = val[15:0];
        REG_SENSOR_HOLD:  sensor_hold = val[6:0];
        REG_SLOW_ZONE:    slow_zone = val[7:0];
        REG_FULL_SPEED:   full_speed = val[7:0];
        default: ;
      endcase
    endfunction

    function void sense_optic(logic lvl);
      if (deb > 0)
        deb = deb - 8'd1;
      if (prev_optic != lvl) begin
        deb = {1'b0, sensor_hold};
        prev_optic = lvl;
        spent = 1'b0;
      end else if (deb == 0 && lvl && !spent) begin
        spent = 1'b1;
        cur = dir ? cur - 16'd1 : cur + 16'd1;
      end
    endfunction

    function void drive_step();
      int c;
      int d;
      int gap;
      logic moved;
      if (status == ST_ERROR) begin
        run = 1'b0;
        return;
      end
      moved = (cur != last);
      if (auto_ctl) begin
        if (cur != dest) begin
          c = $signed(cur);
          d = $signed(dest);
          if (status == ST_READY) begin
            dir = (c > d);
            stall_cnt = stall_ticks;
            status = ST_BUSY;
            done = 1'b0;
            run = 1'b1;
          end
          if (!moved) begin
            stall_cnt = stall_cnt - 16'd1;
            if (stall_cnt == 0) begin
              stall_cnt = 16'd1;
              run = 1'b0;
              status = calib ? ST_READY : ST_ERROR;
            end
          end else begin
            stall_cnt = stall_ticks;
          end
          gap = d - c;
          if (gap < 0)
            gap = -gap;
          if (gap < int'(slow_zone))
            speed = full_speed >> 1;
        end else begin
          done = 1'b1;
          run = 1'b0;
          status = ST_READY;
        end
      end
      last = cur;
    endfunction

    function void head_for(logic [15:0] tgt, logic [7:0] spd);
      if (tgt != cur)
        dest = tgt;
      speed = spd;
      drive_step();
    endfunction

    function void take_request(func_t f, logic lvl, logic [15:0] tgt, logic [7:0] spd);
      reading_t r;
      case (f)
        FN_TICK: begin
          sense_optic(lvl);
          drive_step();
        end
        FN_GOTO_READY: begin
          status = ST_READY;
          head_for(tgt, full_speed);
        end
        FN_GOTO_SPEED: head_for(tgt, spd);
        FN_RESTART: begin
          if (status == ST_ERROR)
            status = ST_READY;
        end
        default: ;
      endcase
      r.position = cur;
      r.status = status;
      r.motor_run = run;
      r.motor_dir = dir;
      r.motor_speed = speed;
      r.dest_complete = done;
      readings_due.push_back(r);
      n_requests++;
    endfunction

    function void check_reading(logic [15:0] position, logic [1:0] st, logic mrun, logic mdir,
                                logic [7:0] mspeed, logic dcomp);
      reading_t e;
      if (readings_due.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = readings_due.pop_front();
      n_checked++;
      if (e.status == ST_ERROR)
        n_error_seen++;
      if (e.dest_complete)
        n_arrived++;
      if (position !== e.position) begin
        $error("position: expected %0d, got %0d", $signed(e.position), $signed(position));
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (mrun !== e.motor_run) begin
        $error("motor_run: expected %0d, got %0d", e.motor_run, mrun);
        errors++;
      end
      if (mdir !== e.motor_dir) begin
        $error("motor_dir: expected %0d, got %0d", e.motor_dir, mdir);
        errors++;
      end
      if (mspeed !== e.motor_speed) begin
        $error("motor_speed: expected %0d, got %0d", e.motor_speed, mspeed);
        errors++;
      end
      if (dcomp !== e.dest_complete) begin
        $error("dest_complete: expected %0d, got %0d", e.dest_complete, dcomp);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_func;
  logic               in_optic_level;
  logic signed [15:0] in_target;
  logic [7:0]         in_speed;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_position;
  logic [1:0]         out_status;
  logic               out_motor_run;
  logic               out_motor_dir;
  logic [7:0]         out_motor_speed;
  logic               out_dest_complete;
  logic               cfg_we;
  logic [CFG_AW-1:0]  cfg_addr;
  logic [CFG_DW-1:0]  cfg_wdata;

  piston_scoreboard sb = new();
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int n_settings = 0;
  logic sensor_level = 1'b0;
  int hold_left = 0;

  piston_position_controller dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_optic_level   (in_optic_level),
    .in_target        (in_target),
    .in_speed         (in_speed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_position     (out_position),
    .out_status       (out_status),
    .out_motor_run    (out_motor_run),
    .out_motor_dir    (out_motor_dir),
    .out_motor_speed  (out_motor_speed),
    .out_dest_complete(out_dest_complete),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.take_request(func_t'(in_func), in_optic_level, in_target, in_speed);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_reading(out_position, out_status, out_motor_run, out_motor_dir,
                       out_motor_speed, out_dest_complete);
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic send_request(func_t f, logic lvl, logic [15:0] tgt, logic [7:0] spd);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_optic_level <= lvl;
    in_target <= tgt;
    in_speed <= spd;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.readings_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_config(logic a, logic c, logic [15:0] st, logic [6:0] od, logic [7:0] sz,
                            logic [7:0] ms);
    logic [CFG_AW-1:0] regs [6];
    logic [CFG_DW-1:0] vals [6];
    regs = '{REG_AUTO_CONTROL, REG_CALIBRATION, REG_STALL_TICKS, REG_SENSOR_HOLD,
             REG_SLOW_ZONE, REG_FULL_SPEED};
    vals = '{{15'd0, a}, {15'd0, c}, st, {9'd0, od}, {8'd0, sz}, {8'd0, ms}};
    drain();
    for (int r = 0; r < 6; r++) begin
      cfg_we <= 1'b1;
      cfg_addr <= regs[r];
      cfg_wdata <= vals[r];
      @(posedge clk);
      sb.write_reg(regs[r], vals[r]);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic set_idling(idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end
      IDLE_SENDER: begin
        in_idle_pct = 65;
        out_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        in_idle_pct = 0;
        out_stall_pct = 65;
      end
      default: begin
        in_idle_pct = 12;
        out_stall_pct = 12;
      end
    endcase
  endtask

  // sensor pattern: mostly full debounce periods, some glitches, some long freezes
  task automatic send_tick();
    int d;
    d = int'(sb.sensor_hold);
    if (hold_left <= 0) begin
      sensor_level = ~sensor_level;
      case ($urandom_range(7))
        0: hold_left = d + $urandom_range(40);
        1: hold_left = $urandom_range(d + 1, 1);
        default: hold_left = d + 1 + $urandom_range(1);
      endcase
    end
    hold_left--;
    send_request(FN_TICK, sensor_level, 16'($urandom), 8'($urandom));
  endtask

  function automatic logic [15:0] pick_target();
    case ($urandom_range(9))
      0, 1: return 16'($urandom);
      2: return sb.cur;
      default: return 16'(sb.cur + $urandom_range(40) - 20);
    endcase
  endfunction

  task automatic run_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 || $urandom_range(59) == 0)
        drain();
      r = $urandom_range(99);
      if (r < 78)
        send_tick();
      else if (r < 87)
        send_request(FN_GOTO_SPEED, 1'($urandom), pick_target(), 8'($urandom));
      else if (r < 94)
        send_request(FN_GOTO_READY, 1'($urandom), pick_target(), 8'($urandom));
      else
        send_request(FN_RESTART, 1'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_phase(idle_mode_t m, logic a, logic c, logic [15:0] st, logic [6:0] od,
                           logic [7:0] sz, logic [7:0] ms, int count);
    set_config(a, c, st, od, sz, ms);
    set_idling(m);
    run_random(count);
  endtask

  task automatic run_directed();
    // reset defaults
    send_request(FN_TICK, 1'b0, 16'h0000, 8'h00);
    send_request(FN_RESTART, 1'b1, 16'hFFFF, 8'hFF);
    send_request(FN_GOTO_SPEED, 1'b0, 16'h7FFF, 8'hFF);
    send_request(FN_GOTO_SPEED, 1'b1, 16'h8000, 8'h00);
    send_request(FN_GOTO_READY, 1'b0, 16'h0000, 8'h5A);   // target equals position
    // move outward through zero to -2
    set_config(1'b1, 1'b0, 16'd3, 7'd1, 8'd255, 8'd255);
    send_request(FN_GOTO_READY, 1'b0, 16'hFFFE, 8'h00);
    send_request(FN_TICK, 1'b1, 16'h0000, 8'h00);
    send_request(FN_TICK, 1'b1, 16'h0000, 8'h00);
    send_request(FN_TICK, 1'b0, 16'h0000, 8'h00);
    send_request(FN_TICK, 1'b1, 16'h0000, 8'h00);
    send_request(FN_TICK, 1'b1, 16'h0000, 8'h00);
    send_request(FN_TICK, 1'b0, 16'h0000, 8'h00);
    // stall into error, then commands while in error
    send_request(FN_GOTO_SPEED, 1'b0, 16'h0001, 8'h07);
    send_request(FN_TICK, 1'b0, 16'h0000, 8'h00);
    send_request(FN_TICK, 1'b0, 16'h0000, 8'h00);
    send_request(FN_TICK, 1'b0, 16'h0000, 8'h00);
    send_request(FN_GOTO_SPEED, 1'b0, 16'h0004, 8'hC8);
    send_request(FN_RESTART, 1'b0, 16'h0000, 8'h00);
    send_request(FN_RESTART, 1'b0, 16'h0000, 8'h00);
    send_request(FN_TICK, 1'b0, 16'h0000, 8'h00);
    send_request(FN_TICK, 1'b0, 16'h0000, 8'h00);
    send_request(FN_TICK, 1'b0, 16'h0000, 8'h00);
    send_request(FN_GOTO_READY, 1'b0, 16'h0004, 8'h00);   // forced ready out of error
    // calibration stall ends in ready, then restarts
    set_config(1'b1, 1'b1, 16'd3, 7'd1, 8'd0, 8'd0);
    send_request(FN_TICK, 1'b0, 16'h0000, 8'h00);
    send_request(FN_TICK, 1'b0, 16'h0000, 8'h00);
    send_request(FN_TICK, 1'b0, 16'h0000, 8'h00);
    // automatic drive off: position still counts
    set_config(1'b0, 1'b0, 16'd3, 7'd1, 8'd5, 8'd100);
    send_request(FN_TICK, 1'b1, 16'h0000, 8'h00);
    send_request(FN_TICK, 1'b1, 16'h0000, 8'h00);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= FN_TICK;
    in_optic_level <= 1'b0;
    in_target <= '0;
    in_speed <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_AUTO_CONTROL;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(IDLE_BOTH);
    run_directed();

    run_phase(IDLE_NONE, 1'b1, 1'b0, 16'd8, 7'd1, 8'd4, 8'd200, 50);
    run_phase(IDLE_SENDER, 1'b1, 1'b1, 16'd5, 7'd2, 8'd255, 8'd255, 50);
    run_phase(IDLE_RECEIVER, 1'b1, 1'b0, 16'd65535, 7'd100, 8'd0, 8'd0, 50);
    run_phase(IDLE_BOTH, 1'b1, 1'b0, 16'd1, 7'd1, 8'd10, 8'd1, 50);
    run_phase(IDLE_NONE, 1'b0, 1'b1, 16'd20, 7'd3, 8'd6, 8'd77, 50);
    run_phase(IDLE_SENDER, 1'b1, 1'b0, 16'($urandom_range(40, 2)), 7'($urandom_range(4, 1)),
              8'($urandom), 8'($urandom), 50);
    run_phase(IDLE_RECEIVER, 1'b1, 1'b1, 16'($urandom_range(30, 2)), 7'($urandom_range(3, 1)),
              8'($urandom), 8'($urandom), 50);
    run_phase(IDLE_BOTH, 1'b1, 1'b0, 16'($urandom_range(12, 1)), 7'($urandom_range(2, 1)),
              8'($urandom), 8'($urandom), 50);

    drain();
    repeat (4) @(posedge clk);

    $display("Sent %0d requests under %0d register settings and four handshake idling patterns.",
             sb.n_requests, n_settings);
    $display("Checked %0d results: %0d in error status, %0d with the destination reached.",
             sb.n_checked, sb.n_error_seen, sb.n_arrived);
    if (sb.errors == 0 && sb.readings_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", sb.readings_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
